FILE: src/tcpc_pkg.sv
// Shared types and constants for the three-cube pair checker.
package tcpc_pkg;

  localparam int BASE_W = 22;             // width of t, y, z
  localparam int TGT_W  = 32;             // target register width
  localparam int SQ_W   = 2 * BASE_W;     // square of a base
  localparam int CUBE_W = 3 * BASE_W;     // cube of a base
  localparam int N_W    = 64;             // remainder to take the cube root of
  localparam int ACC_W  = 68;             // trial cube, with headroom
  localparam int NCELL  = BASE_W;         // one root bit per cell
  localparam int ROOT_LIMIT_DEF = 2642245;

  typedef enum logic [1:0] {
    FORM_NONE = 2'd0,
    FORM_DIFF = 2'd1,
    FORM_SUM  = 2'd2
  } form_t;

  // Running state of one cube-root lane.
  typedef struct packed {
    logic [N_W-1:0]    n;
    logic              ok;
    logic [BASE_W-1:0] r;
    logic [SQ_W-1:0]   r2;
    logic [ACC_W-1:0]  r3;
  } lane_t;

  // Data that rides along with an item through the root cells.
  typedef struct packed {
    logic [BASE_W-1:0] t;
    logic [BASE_W-1:0] y;
  } side_t;

endpackage

FILE: src/tcpc_root_cell.sv
// One cell of the cube-root chain: settles root bit BIT of one lane.
module tcpc_root_cell #(
  parameter int BIT = 0
) (
  input  logic           clk,
  input  logic           en,
  input  tcpc_pkg::lane_t lane_in,
  output tcpc_pkg::lane_t lane_out
);
  import tcpc_pkg::*;

  logic [ACC_W-1:0] r_x;
  logic [ACC_W-1:0] r2_x;
  logic [ACC_W-1:0] t_a;
  logic [ACC_W-1:0] t_b;
  logic [ACC_W-1:0] c3;
  logic [SQ_W-1:0]  c2;
  logic             take;
  lane_t            lane_next;

  // (r+b)^3 = r^3 + 3 r^2 b + 3 r b^2 + b^3 with b = 2^BIT
  always_comb begin
    r_x  = ACC_W'(lane_in.r);
    r2_x = ACC_W'(lane_in.r2);
    t_a  = r2_x << BIT;
    t_b  = r_x << (2 * BIT);
    c3   = lane_in.r3 + t_a + (t_a << 1) + t_b + (t_b << 1)
           + (ACC_W'(1) << (3 * BIT));
    c2   = lane_in.r2 + (SQ_W'(lane_in.r) << (BIT + 1)) + (SQ_W'(1) << (2 * BIT));
    take = c3 <= ACC_W'(lane_in.n);
    lane_next = lane_in;
    if (take) begin
      lane_next.r  = lane_in.r | (BASE_W'(1) << BIT);
      lane_next.r2 = c2;
      lane_next.r3 = c3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_out <= lane_next;
    end
  end

endmodule

FILE: src/three_cube_pair_checker_core.sv
// Top level of the three-cube pair checker.
// Input channel: in_valid / in_stall with t_value, y_value, one pair per item.
// Output channel: out_valid / out_stall with form, z_value, t_echo, y_echo,
// exactly one result item per input item, in input order.
// target_sum is loaded by target_sum_wr; load it only while no item is in flight.
// Pipeline: the pair is registered at the accepting edge, then square, cube
// and difference arithmetic registers, 22 root cells each settling one bit of z,
// and the compare into the output register.
// Throughput: one item per cycle while the output is not stalled; the
// cube-root chain then takes a new pair each cycle; all stages move together.
// When the receiver stalls a shown result, the whole pipe holds and in_stall
// rises in the same cycle; bubbles are kept, not squeezed out.
// Reset clears all valid bits and target_sum to zero; no result is shown
// until new items arrive.
module three_cube_pair_checker_core #(
  parameter int ROOT_LIMIT = tcpc_pkg::ROOT_LIMIT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        target_sum_wr,
  input  logic [tcpc_pkg::TGT_W-1:0]  target_sum,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tcpc_pkg::BASE_W-1:0] t_value,
  input  logic [tcpc_pkg::BASE_W-1:0] y_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  form,
  output logic [tcpc_pkg::BASE_W-1:0] z_value,
  output logic [tcpc_pkg::BASE_W-1:0] t_echo,
  output logic [tcpc_pkg::BASE_W-1:0] y_echo
);
  import tcpc_pkg::*;

  localparam int NSTG = 4 + NCELL + 1;

  logic              adv;
  logic [NSTG-1:0]   vld;
  logic [TGT_W-1:0]  tgt;

  // front stages
  logic [BASE_W-1:0] s0_t, s0_y, s1_t, s1_y, s2_t, s2_y;
  logic              s0_in, s1_in, s2_in;
  logic [SQ_W-1:0]   s1_t2, s1_y2;
  // cube as two partial products: high and low half of the square times the base
  logic [SQ_W-1:0]   s2_t3h, s2_t3l, s2_y3h, s2_y3l;
  logic [CUBE_W-1:0] t3, y3;

  logic signed [ACC_W-1:0] d;
  logic signed [ACC_W-1:0] e;
  logic signed [ACC_W-1:0] tgt_s;

  lane_t l1 [NCELL+1];
  lane_t l2 [NCELL+1];
  side_t sd [NCELL+1];

  logic  m1, m2;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      tgt <= '0;
    end else begin
      if (target_sum_wr) begin
        tgt <= target_sum;
      end
      if (adv) begin
        vld <= {vld[NSTG-2:0], in_valid};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_t  <= t_value;
      s0_y  <= y_value;
      s0_in <= (32'(t_value) <= 32'(ROOT_LIMIT)) && (32'(y_value) <= 32'(ROOT_LIMIT));
      s1_t  <= s0_t;
      s1_y  <= s0_y;
      s1_in <= s0_in;
      s1_t2 <= SQ_W'(s0_t) * SQ_W'(s0_t);
      s1_y2 <= SQ_W'(s0_y) * SQ_W'(s0_y);
      s2_t  <= s1_t;
      s2_y  <= s1_y;
      s2_in <= s1_in;
      s2_t3h <= SQ_W'(s1_t2[SQ_W-1:BASE_W]) * SQ_W'(s1_t);
      s2_t3l <= SQ_W'(s1_t2[BASE_W-1:0]) * SQ_W'(s1_t);
      s2_y3h <= SQ_W'(s1_y2[SQ_W-1:BASE_W]) * SQ_W'(s1_y);
      s2_y3l <= SQ_W'(s1_y2[BASE_W-1:0]) * SQ_W'(s1_y);
    end
  end

  // d = t^3 - y^3 ; form 1 takes d - target, form 2 takes d + target
  always_comb begin
    t3    = (CUBE_W'(s2_t3h) << BASE_W) + CUBE_W'(s2_t3l);
    y3    = (CUBE_W'(s2_y3h) << BASE_W) + CUBE_W'(s2_y3l);
    tgt_s = $signed(ACC_W'(tgt));
    d     = $signed(ACC_W'(t3)) - $signed(ACC_W'(y3));
    e     = d + tgt_s;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[0].t  <= s2_t;
      sd[0].y  <= s2_y;
      l1[0].n  <= N_W'(d - tgt_s);
      l1[0].ok <= s2_in && (d >= tgt_s);
      l1[0].r  <= '0;
      l1[0].r2 <= '0;
      l1[0].r3 <= '0;
      l2[0].n  <= N_W'(e);
      l2[0].ok <= s2_in && (y3 >= CUBE_W'(tgt)) && !e[ACC_W-1];
      l2[0].r  <= '0;
      l2[0].r2 <= '0;
      l2[0].r3 <= '0;
    end
  end

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    tcpc_root_cell #(.BIT(NCELL-1-i)) u_c1 (
      .clk(clk), .en(adv), .lane_in(l1[i]), .lane_out(l1[i+1]));
    tcpc_root_cell #(.BIT(NCELL-1-i)) u_c2 (
      .clk(clk), .en(adv), .lane_in(l2[i]), .lane_out(l2[i+1]));
    always_ff @(posedge clk) begin
      if (adv) begin
        sd[i+1] <= sd[i];
      end
    end
  end

  assign m1 = l1[NCELL].ok && (l1[NCELL].r3 == ACC_W'(l1[NCELL].n))
              && (l1[NCELL].r < sd[NCELL].t);
  assign m2 = l2[NCELL].ok && (l2[NCELL].r3 == ACC_W'(l2[NCELL].n))
              && (l2[NCELL].r < sd[NCELL].t);

  always_ff @(posedge clk) begin
    if (adv) begin
      t_echo <= sd[NCELL].t;
      y_echo <= sd[NCELL].y;
      priority if (m1) begin
        form    <= FORM_DIFF;
        z_value <= l1[NCELL].r;
      end else if (m2) begin
        form    <= FORM_SUM;
        z_value <= l2[NCELL].r;
      end else begin
        form    <= FORM_NONE;
        z_value <= '0;
      end
    end
  end

endmodule

FILE: src/tcpc_checker.sv
// Port-level checks for the three-cube pair checker, bound to the top level.
module tcpc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [1:0]                  form,
  input logic [tcpc_pkg::BASE_W-1:0] z_value,
  input logic [tcpc_pkg::BASE_W-1:0] t_echo
);
  import tcpc_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(form) && $stable(z_value))
    else $error("stalled result changed");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && form == FORM_NONE |-> z_value == '0)
    else $error("z nonzero without match");

  a_below: assert property (@(posedge clk) disable iff (rst)
    out_valid && form != FORM_NONE |-> z_value < t_echo)
    else $error("z not below t");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

endmodule

bind three_cube_pair_checker_core tcpc_checker u_tcpc_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .form(form), .z_value(z_value), .t_echo(t_echo));
